// ===== sv/assert_macros.svh =====
// assertion macros for the trimmed mean block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== sv/swtm_pkg.sv =====
// shared types and constants for the trimmed mean block
package swtm_pkg;
	localparam int MaxWindow  = 1024;
	localparam int SampleBits = 16;
	localparam int IdxBits    = $clog2(MaxWindow);
	localparam int LenBits    = 11;
	localparam int TrimBits   = 9;
	localparam int SumBits    = 26;
	localparam int CfgIdxBits = 32;
	localparam int CfgDatBits = 32;

	localparam logic [CfgIdxBits-1:0] RegWindowLen = 32'd0;
	localparam logic [CfgIdxBits-1:0] RegTrimCount = 32'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVRD,
		ST_EVCHK,
		ST_EVSHIFT,
		ST_INSRD,
		ST_INSCHK,
		ST_SUMRD,
		ST_SUMACC,
		ST_DIV,
		ST_OUT
	} state_t;
endpackage

// ===== sv/sliding_window_trimmed_mean.sv =====
// top level: sliding window trimmed mean with sequencer, ring and sorted memories
// Usage:
//   sample_valid/sample_ready take one 16-bit sample word. Each sample gives
//   one result word on result_valid/result_ready: trimmed_mean and mean_valid.
//   cfg_valid/cfg_ready write window_len (index 0) or trim_count (index 1);
//   any such write empties the window. Write only when the block is idle.
// Sequence:
//   with a full window the block first walks the sorted copy from the bottom
//   to remove the evicted word, one entry per cycle; the new word is then
//   inserted from the top, each larger entry shifted up, with a read and a
//   check state per entry; the middle entries are summed, with a read and an
//   accumulate state per entry; and the serial divider forms the mean. Before
//   the window is full there is no eviction and no divide.
//   sample_ready is low from acceptance until the result word is taken,
//   and also while cfg_valid is high.
// Reset:
//   window empty, window_len 3, trim_count 1; memories are not cleared.
// Stall:
//   the result word holds until result_ready; no new sample meanwhile.
`include "assert_macros.svh"
module sliding_window_trimmed_mean (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [swtm_pkg::SampleBits-1:0] sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [15:0]                     trimmed_mean,
	output logic                            mean_valid,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swtm_pkg::CfgIdxBits-1:0] cfg_index,
	input  logic [swtm_pkg::CfgDatBits-1:0] cfg_data
);
	import swtm_pkg::*;

	state_t state_q, state_d;

	logic [LenBits-1:0]    wlen_q;
	logic [TrimBits-1:0]   trim_q;
	logic [IdxBits-1:0]    head_q;
	logic [LenBits-1:0]    fill_q;
	logic [SumBits-1:0]    sum_q;
	logic [SampleBits-1:0] samp_q;
	logic [SampleBits-1:0] evict_q;
	logic [LenBits-1:0]    ptr_q;
	logic [LenBits-1:0]    end_q;
	logic                  found_q;
	logic [15:0]           mean_q;
	logic                  mvalid_q;

	logic [LenBits-1:0]    len;
	logic [LenBits:0]      twice;
	logic                  full;

	// memories
	logic                  ring_we;
	logic [SampleBits-1:0] ring_rd;
	logic                  srt_we;
	logic [IdxBits-1:0]    srt_waddr;
	logic [SampleBits-1:0] srt_wdata;
	logic [IdxBits-1:0]    srt_raddr;
	logic [SampleBits-1:0] srt_rd;

	// divider
	logic                  div_start;
	logic                  div_done;
	logic [SumBits-1:0]    quo;

	// active window length, clipped to the memory depth
	assign len   = (wlen_q > LenBits'(MaxWindow)) ? LenBits'(MaxWindow) : wlen_q;
	assign twice = {trim_q, 1'b0} + (LenBits+1)'(0);
	assign full  = (fill_q >= len);

	swtm_ram #(.Depth(MaxWindow), .Width(SampleBits)) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(head_q),
		.wdata(samp_q),
		.raddr(head_q),
		.rdata(ring_rd)
	);

	swtm_ram #(.Depth(MaxWindow), .Width(SampleBits)) u_sorted (
		.clk  (clk),
		.we   (srt_we),
		.waddr(srt_waddr),
		.wdata(srt_wdata),
		.raddr(srt_raddr),
		.rdata(srt_rd)
	);

	swtm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (len - twice[LenBits-1:0]),
		.done    (div_done),
		.quotient(quo)
	);

	// a register write takes the idle slot ahead of a sample
	assign sample_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = (state_q == ST_OUT);
	assign trimmed_mean = mean_q;
	assign mean_valid   = mvalid_q;

	// sequencer next state and memory strobes
	always_comb begin
		state_d    = state_q;
		ring_we    = 1'b0;
		srt_we     = 1'b0;
		srt_waddr  = ptr_q[IdxBits-1:0];
		srt_wdata  = srt_rd;
		srt_raddr  = ptr_q[IdxBits-1:0];
		div_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid && !cfg_valid) begin
					state_d = (len == '0) ? ST_SUMRD : ST_EVRD;
				end
			end
			ST_EVRD: begin
				state_d = full ? ST_EVCHK : ST_INSRD;
			end
			ST_EVCHK: begin
				// ring_rd holds the evicted word; search walk
				if (ptr_q >= fill_q) begin
					state_d = ST_INSRD;
				end else begin
					state_d = ST_EVSHIFT;
				end
			end
			ST_EVSHIFT: begin
				// srt_rd holds entry ptr; shift down once found
				if (found_q) begin
					srt_we    = 1'b1;
					srt_waddr = IdxBits'(ptr_q - 1'b1);
				end
				if (ptr_q + 1'b1 >= fill_q) begin
					state_d = ST_INSRD;
				end else begin
					state_d = ST_EVSHIFT;
				end
				srt_raddr = IdxBits'(ptr_q + 1'b1);
			end
			ST_INSRD: begin
				ring_we   = 1'b1;
				srt_raddr = IdxBits'(ptr_q - 1'b1);
				state_d   = ST_INSCHK;
			end
			ST_INSCHK: begin
				// srt_rd holds entry ptr-1
				if (ptr_q != '0 && srt_rd > samp_q) begin
					srt_we    = 1'b1;
					srt_wdata = srt_rd;
					state_d   = ST_INSRD;
				end else begin
					srt_we    = 1'b1;
					srt_wdata = samp_q;
					state_d   = ST_SUMRD;
				end
			end
			ST_SUMRD: begin
				if (len == '0 || fill_q != len || twice >= {1'b0, len}) begin
					state_d = ST_OUT;
				end else if (ptr_q >= end_q) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_SUMACC;
				end
			end
			ST_SUMACC: begin
				state_d = ST_SUMRD;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= LenBits'(3);
			trim_q   <= TrimBits'(1);
			head_q   <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			mvalid_q <= 1'b0;
			mean_q   <= '0;
			ptr_q    <= '0;
			end_q    <= '0;
			found_q  <= 1'b0;
			samp_q   <= '0;
			evict_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == RegWindowLen) begin
							wlen_q <= cfg_data[LenBits-1:0];
							head_q <= '0;
							fill_q <= '0;
							sum_q  <= '0;
						end else if (cfg_index == RegTrimCount) begin
							trim_q <= cfg_data[TrimBits-1:0];
							head_q <= '0;
							fill_q <= '0;
							sum_q  <= '0;
						end
					end else if (sample_valid) begin
						samp_q  <= sample;
						found_q <= 1'b0;
						ptr_q   <= LenBits'(trim_q);
						if (len != '0) begin
							if ({1'b0, head_q} >= len) begin
								head_q <= '0;
							end
							if (fill_q > len) begin
								fill_q <= len;
							end
						end
					end
				end
				ST_EVRD: begin
					// eviction search starts at the bottom, insertion at the top
					ptr_q <= full ? '0 : fill_q;
				end
				ST_EVCHK: begin
					evict_q <= ring_rd;
					if (ptr_q >= fill_q) begin
						ptr_q <= fill_q;
					end
				end
				ST_EVSHIFT: begin
					if (!found_q && srt_rd == evict_q) begin
						found_q <= 1'b1;
					end
					if (ptr_q + 1'b1 >= fill_q) begin
						if (found_q || srt_rd == evict_q) begin
							fill_q <= fill_q - 1'b1;
							ptr_q  <= fill_q - 1'b1;
						end else begin
							ptr_q <= fill_q;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_INSRD: begin
					if (ptr_q == '0) begin
						ptr_q <= ptr_q;
					end
				end
				ST_INSCHK: begin
					if (ptr_q != '0 && srt_rd > samp_q) begin
						ptr_q <= ptr_q - 1'b1;
					end else begin
						fill_q <= fill_q + 1'b1;
						head_q <= ({1'b0, head_q} + 1'b1 == len) ? '0 : head_q + 1'b1;
						ptr_q  <= LenBits'(trim_q);
						end_q  <= len - LenBits'(trim_q);
						sum_q  <= '0;
					end
				end
				ST_SUMRD: begin
					if (len == '0 || fill_q != len || twice >= {1'b0, len}) begin
						mvalid_q <= 1'b0;
						mean_q   <= '0;
						sum_q    <= '0;
					end
				end
				ST_SUMACC: begin
					sum_q <= sum_q + SumBits'(srt_rd);
					ptr_q <= ptr_q + 1'b1;
				end
				ST_DIV: begin
					if (div_done) begin
						mvalid_q <= 1'b1;
						mean_q   <= quo[15:0];
					end
				end
				ST_OUT: begin
				end
				default: begin
				end
			endcase
		end
	end

	`ASSERT_IMP(a_out_hold, clk, arst_n, result_valid && !result_ready, state_d == ST_OUT)
	`ASSERT_IMP(a_zero_invalid, clk, arst_n, result_valid && !mean_valid, trimmed_mean == '0)
	`ASSERT_NEXT(a_not_ready_busy, clk, arst_n, sample_valid && sample_ready, !sample_ready)
	`ASSERT_IMP(a_fill_bound, clk, arst_n, result_valid && len != '0, fill_q <= len)
endmodule

// ===== sv/swtm_ram.sv =====
// single-port-write, single-port-read memory with registered read
module swtm_ram #(
	parameter int Depth = 1024,
	parameter int Width = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/swtm_div.sv =====
// restoring divider, one quotient bit per cycle
module swtm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [swtm_pkg::SumBits-1:0] dividend,
	input  logic [swtm_pkg::LenBits-1:0] divisor,
	output logic                        done,
	output logic [swtm_pkg::SumBits-1:0] quotient
);
	import swtm_pkg::*;

	localparam int CntBits = $clog2(SumBits + 1);

	logic [SumBits-1:0] quo_q;
	logic [LenBits:0]   rem_q;
	logic [LenBits-1:0] dvs_q;
	logic [CntBits-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [LenBits:0]   trial;

	// shift in next dividend bit
	assign trial = {rem_q[LenBits-1:0], quo_q[SumBits-1]};

	// iteration register; done rises once the last quotient bit has landed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CntBits'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(SumBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[SumBits-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SumBits-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
